// ===== rtl/core/mesh_vertex_normal_accumulator_macros.svh =====
// Assertion macros for the mesh vertex normal accumulator.
// Expects signals clk and rst_n in the scope of use.
`ifndef MESH_VERTEX_NORMAL_ACCUMULATOR_MACROS_SVH
`define MESH_VERTEX_NORMAL_ACCUMULATOR_MACROS_SVH

// Same-cycle implication.
`define MVNA_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MVNA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mvna_pkg.sv =====
// Shared types and codes for the mesh vertex normal accumulator.
// No dependencies; used by the datapath, controller and top level.
package mvna_pkg;

    // Operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_TRI   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Datapath step codes
    localparam logic [3:0] STEP_NOP   = 4'd0;
    localparam logic [3:0] STEP_CLEAR = 4'd1;
    localparam logic [3:0] STEP_LOAD  = 4'd2;
    localparam logic [3:0] STEP_WRITE = 4'd3;
    localparam logic [3:0] STEP_PRD   = 4'd4;
    localparam logic [3:0] STEP_MUL   = 4'd5;
    localparam logic [3:0] STEP_SRD   = 4'd6;
    localparam logic [3:0] STEP_SCAP  = 4'd7;
    localparam logic [3:0] STEP_ABS   = 4'd8;
    localparam logic [3:0] STEP_SHIFT = 4'd9;
    localparam logic [3:0] STEP_SQ    = 4'd10;
    localparam logic [3:0] STEP_SQRT  = 4'd11;
    localparam logic [3:0] STEP_DIV   = 4'd12;
    localparam logic [3:0] STEP_ACC   = 4'd13;
    localparam logic [3:0] STEP_OUT   = 4'd14;

    // Corner / component select codes
    localparam logic [1:0] SEL_A      = 2'd0;
    localparam logic [1:0] SEL_B      = 2'd1;
    localparam logic [1:0] SEL_C      = 2'd2;
    localparam logic [1:0] SEL_VERTEX = 2'd3;

    // Last count of each multi-cycle step
    localparam logic [5:0] PRD_LAST  = 6'd3;
    localparam logic [5:0] MUL_LAST  = 6'd6;
    localparam logic [5:0] SQ_LAST   = 6'd3;
    localparam logic [5:0] SQRT_LAST = 6'd32;
    localparam logic [5:0] DIV_LAST  = 6'd16;

    typedef struct packed {
        logic [1:0]         operation;
        logic [9:0]         vertex_index;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic [9:0]         corner_a;
        logic [9:0]         corner_b;
        logic [9:0]         corner_c;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic               degenerate;
        logic               saturated;
    } out_word_t;

    typedef struct packed {
        logic [3:0] step;
        logic [5:0] cnt;
        logic [1:0] sel;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       clr_last;
        logic       shift_done;
        logic       len_zero;
    } dp_stat_t;

endpackage

// ===== rtl/core/mvna_stream_if.sv =====
// Valid/ready stream channel carrying one word of type T.
// Payload types come from mvna_pkg.
interface mvna_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

// ===== rtl/core/mesh_vertex_normal_accumulator.sv =====
// Mesh vertex normal accumulator. Holds a Q8.15 position and a saturating Q.14
// normal sum per vertex. One request word is handled at a time; the response
// word sits in an output register, so the next request is taken while it
// waits. A triangle and a normal read both pass through the shared
// normalization unit: one-bit magnitude shifting, a bit-serial square root and
// three restoring divisions, the divisions skipped when the cross product or
// the sum is zero. A response not yet taken holds the next one back until it
// is taken. After reset the sum RAM is cleared one entry a cycle, so no request
// is taken until every entry is cleared.
// Depends on mvna_pkg, mvna_stream_if, mvna_controller, mvna_datapath.
`include "mesh_vertex_normal_accumulator_macros.svh"

module mesh_vertex_normal_accumulator #(
    parameter int MAX_VERTICES = 1024,
    parameter int SUM_WIDTH    = 20
) (
    input  logic         clk,
    input  logic         rst_n,
    mvna_stream_if.sink   request,
    mvna_stream_if.source response
);
    import mvna_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     req_take;
    logic     resp_free;
    logic     resp_deg;
    logic     resp_zero;

    mvna_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (request.valid),
        .req_ready  (request.ready),
        .resp_valid (response.valid),
        .resp_ready (response.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    mvna_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .SUM_WIDTH    (SUM_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_word  (request.word),
        .cmd       (cmd),
        .stat      (stat),
        .resp_word (response.word)
    );

    // terms for the checks below
    assign req_take  = request.valid && request.ready;
    assign resp_free = !response.valid || response.ready;
    assign resp_deg  = response.valid && response.word.degenerate;
    assign resp_zero = (response.word.normal_x == 16'sd0) && (response.word.normal_y == 16'sd0)
                    && (response.word.normal_z == 16'sd0);

    // one request in flight at a time
    `MVNA_ASSERT_NEXT(a_single_flight, req_take, !request.ready, "request accepted while busy")
    // a new response never overwrites one not yet taken
    `MVNA_ASSERT_IMPLIES(a_no_overwrite, cmd.step == STEP_OUT, resp_free, "response overwritten")
    // degenerate results carry a zero normal
    `MVNA_ASSERT_IMPLIES(a_deg_zero, resp_deg, resp_zero, "degenerate with nonzero normal")

endmodule

// ===== rtl/core/mvna_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mvna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/mvna_datapath.sv =====
// Datapath: position and sum RAMs, cross product, normalization unit
// (shift, square root, divider) and saturating accumulate. Uses mvna_pkg, mvna_ram.
module mvna_datapath #(
    parameter int MAX_VERTICES = 1024,
    parameter int SUM_WIDTH    = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mvna_pkg::in_word_t  req_word,
    input  mvna_pkg::dp_cmd_t   cmd,
    output mvna_pkg::dp_stat_t  stat,
    output mvna_pkg::out_word_t resp_word
);
    import mvna_pkg::*;

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int RECIP = (1 << 20) / MAX_VERTICES;
    localparam int VEC_W = 52;
    localparam int MAG_W = 51;
    localparam int PRD_W = 62;
    localparam logic signed [SUM_WIDTH:0] SMAX = {2'b00, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH:0] SMIN = {2'b11, {(SUM_WIDTH-1){1'b0}}};

    // index modulo MAX_VERTICES by reciprocal multiply and one correction
    function automatic logic [IDX_W-1:0] reduce_idx(input logic [9:0] v);
        logic [29:0] prod;
        logic [9:0]  q;
        logic [26:0] qm;
        logic [16:0] r;
        prod = 30'(v) * 30'(RECIP);
        q    = prod[29:20];
        qm   = 27'(q) * 27'(MAX_VERTICES);
        r    = 17'(v) - qm[16:0];
        if (r >= 17'(MAX_VERTICES))
        begin
            r = r - 17'(MAX_VERTICES);
        end
        return r[IDX_W-1:0];
    endfunction

    // captured request
    logic [1:0]         op_reg;
    logic [9:0]         vraw_reg, araw_reg, braw_reg, craw_reg;
    logic [71:0]        posw_reg;
    // geometry
    logic signed [24:0] pa_reg [3];
    logic signed [24:0] e1_reg [3];
    logic signed [24:0] e2_reg [3];
    logic signed [PRD_W-1:0] prod_reg;
    logic signed [VEC_W-1:0] vec_reg [3];
    logic [MAG_W-1:0]   mag_reg [3];
    logic               neg_reg [3];
    // normalization
    logic [61:0]        l2_reg;
    logic [61:0]        x_reg;
    logic [62:0]        r_reg;
    logic [62:0]        bit_reg;
    logic [32:0]        rem_reg;
    logic [14:0]        nlow_reg;
    logic [14:0]        quo_reg;
    logic signed [15:0] n_reg [3];
    logic               deg_reg, sat_reg;
    logic [IDX_W-1:0]   clr_reg;
    out_word_t          out_reg;

    logic [IDX_W-1:0] vidx, ca, cb, cc, corner, pos_raddr, sum_waddr;
    logic             pos_we, sum_we;
    logic [71:0]      pos_rd;
    logic [3*SUM_WIDTH-1:0] sum_rd, sum_wd, acc_word;
    logic signed [24:0] rd_pos [3];
    logic signed [30:0] mul_a, mul_b;
    logic [5:0]         kcnt;
    logic [31:0]        len;
    logic [MAG_W-1:0]   mag_sel;
    logic               neg_sel;
    logic [44:0]        num;
    logic [32:0]        trial;
    logic [63:0]        rb;
    logic [2:0]         acc_sat;
    logic               shift_done;

    assign vidx = reduce_idx(vraw_reg);
    assign ca   = reduce_idx(araw_reg);
    assign cb   = reduce_idx(braw_reg);
    assign cc   = reduce_idx(craw_reg);
    assign len  = r_reg[31:0];

    // corner select for sum access
    always_comb
    begin
        case (cmd.sel)
            SEL_A:   corner = ca;
            SEL_B:   corner = cb;
            SEL_C:   corner = cc;
            default: corner = vidx;
        endcase
    end

    // position RAM port selection
    always_comb
    begin
        case (cmd.cnt[1:0])
            2'd0:    pos_raddr = ca;
            2'd1:    pos_raddr = cb;
            default: pos_raddr = cc;
        endcase
    end
    assign pos_we = (cmd.step == STEP_WRITE);

    mvna_ram #(.WIDTH(72), .DEPTH(MAX_VERTICES)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (vidx),
        .wdata (posw_reg),
        .raddr (pos_raddr),
        .rdata (pos_rd)
    );

    // sum RAM: cleared after reset and on write, updated by accumulate
    assign sum_we = (cmd.step == STEP_CLEAR) || (cmd.step == STEP_WRITE)
                 || (cmd.step == STEP_ACC);
    always_comb
    begin
        case (cmd.step)
            STEP_CLEAR: sum_waddr = clr_reg;
            STEP_WRITE: sum_waddr = vidx;
            default:    sum_waddr = corner;
        endcase
        sum_wd = (cmd.step == STEP_ACC) ? acc_word : '0;
    end

    mvna_ram #(.WIDTH(3*SUM_WIDTH), .DEPTH(MAX_VERTICES)) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wd),
        .raddr (corner),
        .rdata (sum_rd)
    );

    // saturating add of the normal into a stored sum
    always_comb
    begin
        logic signed [SUM_WIDTH:0] s;
        for (int i = 0; i < 3; i++)
        begin
            s = (SUM_WIDTH+1)'(signed'(sum_rd[SUM_WIDTH*i +: SUM_WIDTH]))
              + (SUM_WIDTH+1)'(n_reg[i]);
            acc_sat[i] = 1'b0;
            if (s > SMAX)
            begin
                s = SMAX;
                acc_sat[i] = 1'b1;
            end
            if (s < SMIN)
            begin
                s = SMIN;
                acc_sat[i] = 1'b1;
            end
            acc_word[SUM_WIDTH*i +: SUM_WIDTH] = s[SUM_WIDTH-1:0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rd_pos[i] = 25'(signed'(pos_rd[24*i +: 24]));
        end
    end

    // shared multiplier operands: cross terms, then squares
    assign kcnt = cmd.cnt - 6'd1;
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.step == STEP_SQ)
        begin
            case (cmd.cnt[1:0])
                2'd0:    mul_a = {1'b0, mag_reg[0][29:0]};
                2'd1:    mul_a = {1'b0, mag_reg[1][29:0]};
                default: mul_a = {1'b0, mag_reg[2][29:0]};
            endcase
            mul_b = mul_a;
        end
        else
        begin
            case (cmd.cnt[2:0])
                3'd0:    begin mul_a = 31'(e1_reg[1]); mul_b = 31'(e2_reg[2]); end
                3'd1:    begin mul_a = 31'(e1_reg[2]); mul_b = 31'(e2_reg[1]); end
                3'd2:    begin mul_a = 31'(e1_reg[2]); mul_b = 31'(e2_reg[0]); end
                3'd3:    begin mul_a = 31'(e1_reg[0]); mul_b = 31'(e2_reg[2]); end
                3'd4:    begin mul_a = 31'(e1_reg[0]); mul_b = 31'(e2_reg[1]); end
                default: begin mul_a = 31'(e1_reg[1]); mul_b = 31'(e2_reg[0]); end
            endcase
        end
    end

    // divider operand and one restoring step
    always_comb
    begin
        case (cmd.sel)
            SEL_A:   begin mag_sel = mag_reg[0]; neg_sel = neg_reg[0]; end
            SEL_B:   begin mag_sel = mag_reg[1]; neg_sel = neg_reg[1]; end
            default: begin mag_sel = mag_reg[2]; neg_sel = neg_reg[2]; end
        endcase
        num   = {1'b0, mag_sel[29:0], 14'd0} + 45'(len >> 1);
        trial = {rem_reg[31:0], nlow_reg[14]};
        rb    = 64'(r_reg) + 64'(bit_reg);
    end

    assign shift_done = (mag_reg[0][MAG_W-1:30] == '0) && (mag_reg[1][MAG_W-1:30] == '0)
                     && (mag_reg[2][MAG_W-1:30] == '0);

    // clear pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.step == STEP_CLEAR)
        begin
            clr_reg <= clr_reg + IDX_W'(1);
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (cmd.step)
            STEP_LOAD:
            begin
                op_reg   <= req_word.operation;
                vraw_reg <= req_word.vertex_index;
                araw_reg <= req_word.corner_a;
                braw_reg <= req_word.corner_b;
                craw_reg <= req_word.corner_c;
                posw_reg <= {req_word.pos_z, req_word.pos_y, req_word.pos_x};
                for (int i = 0; i < 3; i++)
                begin
                    n_reg[i] <= '0;
                end
                deg_reg <= 1'b0;
                sat_reg <= 1'b0;
            end
            STEP_PRD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (cmd.cnt == 6'd1)
                    begin
                        pa_reg[i] <= rd_pos[i];
                    end
                    if (cmd.cnt == 6'd2)
                    begin
                        e1_reg[i] <= rd_pos[i] - pa_reg[i];
                    end
                    if (cmd.cnt == 6'd3)
                    begin
                        e2_reg[i] <= rd_pos[i] - pa_reg[i];
                    end
                end
            end
            STEP_MUL:
            begin
                prod_reg <= PRD_W'(mul_a) * PRD_W'(mul_b);
                if (cmd.cnt != 6'd0)
                begin
                    if (!kcnt[0])
                    begin
                        vec_reg[kcnt[2:1]] <= signed'(prod_reg[VEC_W-1:0]);
                    end
                    else
                    begin
                        vec_reg[kcnt[2:1]] <= vec_reg[kcnt[2:1]]
                                            - signed'(prod_reg[VEC_W-1:0]);
                    end
                end
            end
            STEP_SCAP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    vec_reg[i] <= VEC_W'(signed'(sum_rd[SUM_WIDTH*i +: SUM_WIDTH]));
                    if ((sum_rd[SUM_WIDTH*i +: SUM_WIDTH] == SMAX[SUM_WIDTH-1:0])
                        || (sum_rd[SUM_WIDTH*i +: SUM_WIDTH] == SMIN[SUM_WIDTH-1:0]))
                    begin
                        sat_reg <= 1'b1;
                    end
                end
            end
            STEP_ABS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    neg_reg[i] <= vec_reg[i][VEC_W-1];
                    mag_reg[i] <= vec_reg[i][VEC_W-1] ? MAG_W'(-vec_reg[i])
                                                      : MAG_W'(vec_reg[i]);
                end
                l2_reg <= '0;
            end
            STEP_SHIFT:
            begin
                if (!shift_done)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                end
            end
            STEP_SQ:
            begin
                prod_reg <= PRD_W'(mul_a) * PRD_W'(mul_b);
                if (cmd.cnt != 6'd0)
                begin
                    l2_reg <= l2_reg + prod_reg[61:0];
                end
            end
            STEP_SQRT:
            begin
                if (cmd.cnt == 6'd0)
                begin
                    x_reg   <= l2_reg;
                    r_reg   <= '0;
                    bit_reg <= 63'(1) << 62;
                end
                else
                begin
                    if (64'(x_reg) >= rb)
                    begin
                        x_reg <= x_reg - rb[61:0];
                        r_reg <= (r_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        r_reg <= r_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
            end
            STEP_DIV:
            begin
                if (cmd.cnt == 6'd0)
                begin
                    rem_reg  <= 33'(num[44:15]);
                    nlow_reg <= num[14:0];
                    quo_reg  <= '0;
                    if (len == '0)
                    begin
                        deg_reg <= 1'b1;
                    end
                end
                else if (cmd.cnt == DIV_LAST)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (cmd.sel == 2'(i))
                        begin
                            n_reg[i] <= neg_sel ? -signed'({1'b0, quo_reg})
                                                : signed'({1'b0, quo_reg});
                        end
                    end
                end
                else
                begin
                    nlow_reg <= nlow_reg << 1;
                    if (trial >= {1'b0, len})
                    begin
                        rem_reg <= trial - {1'b0, len};
                        quo_reg <= {quo_reg[13:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= trial;
                        quo_reg <= {quo_reg[13:0], 1'b0};
                    end
                end
            end
            STEP_ACC:
            begin
                if (acc_sat != 3'b000)
                begin
                    sat_reg <= 1'b1;
                end
            end
            STEP_OUT:
            begin
                out_reg.normal_x   <= n_reg[0];
                out_reg.normal_y   <= n_reg[1];
                out_reg.normal_z   <= n_reg[2];
                out_reg.degenerate <= deg_reg;
                out_reg.saturated  <= sat_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign resp_word       = out_reg;
    assign stat.op         = op_reg;
    assign stat.clr_last   = (clr_reg == IDX_W'(MAX_VERTICES - 1));
    assign stat.shift_done = shift_done;
    assign stat.len_zero   = (len == '0);
endmodule

// ===== rtl/core/mvna_controller.sv =====
// Controller state machine: sequences the datapath steps for each operation
// and owns the request/response handshake. Uses mvna_pkg.
module mvna_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               resp_valid,
    input  logic               resp_ready,
    input  mvna_pkg::dp_stat_t stat,
    output mvna_pkg::dp_cmd_t  cmd
);
    import mvna_pkg::*;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_DISP  = 4'd2;
    localparam logic [3:0] ST_WRITE = 4'd3;
    localparam logic [3:0] ST_PRD   = 4'd4;
    localparam logic [3:0] ST_MUL   = 4'd5;
    localparam logic [3:0] ST_SRD   = 4'd6;
    localparam logic [3:0] ST_SCAP  = 4'd7;
    localparam logic [3:0] ST_ABS   = 4'd8;
    localparam logic [3:0] ST_SHIFT = 4'd9;
    localparam logic [3:0] ST_SQ    = 4'd10;
    localparam logic [3:0] ST_SQRT  = 4'd11;
    localparam logic [3:0] ST_DIV   = 4'd12;
    localparam logic [3:0] ST_ACC   = 4'd13;
    localparam logic [3:0] ST_OUT   = 4'd14;

    logic [3:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [1:0] sel_reg, sel_next;
    logic       resp_valid_reg, resp_valid_next;

    // next-state and step decode
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        req_ready  = 1'b0;
        cmd.step   = STEP_NOP;
        cmd.cnt    = cnt_reg;
        cmd.sel    = sel_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.step = STEP_CLEAR;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.step   = STEP_LOAD;
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                cnt_next = '0;
                sel_next = SEL_VERTEX;
                unique case (stat.op)
                    OP_WRITE: state_next = ST_WRITE;
                    OP_TRI:   state_next = ST_PRD;
                    OP_READ:  state_next = ST_SRD;
                    default:  state_next = ST_OUT;
                endcase
            end
            ST_WRITE:
            begin
                cmd.step   = STEP_WRITE;
                state_next = ST_OUT;
            end
            ST_PRD:
            begin
                cmd.step = STEP_PRD;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == PRD_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.step = STEP_MUL;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = ST_ABS;
                end
            end
            ST_SRD:
            begin
                cmd.step   = STEP_SRD;
                state_next = (stat.op == OP_READ) ? ST_SCAP : ST_ACC;
            end
            ST_SCAP:
            begin
                cmd.step   = STEP_SCAP;
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                cmd.step   = STEP_ABS;
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                cmd.step = STEP_SHIFT;
                if (stat.shift_done)
                begin
                    cnt_next   = '0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                cmd.step = STEP_SQ;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == SQ_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                cmd.step = STEP_SQRT;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == SQRT_LAST)
                begin
                    cnt_next   = '0;
                    sel_next   = SEL_A;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.step = STEP_DIV;
                cnt_next = cnt_reg + 6'd1;
                // zero length skips the divisions and leaves a zero normal
                if (stat.len_zero || (cnt_reg == DIV_LAST && sel_reg == SEL_C))
                begin
                    cnt_next   = '0;
                    sel_next   = SEL_A;
                    state_next = (stat.op == OP_READ) ? ST_OUT : ST_SRD;
                end
                else if (cnt_reg == DIV_LAST)
                begin
                    cnt_next = '0;
                    sel_next = sel_reg + 2'd1;
                end
            end
            ST_ACC:
            begin
                cmd.step = STEP_ACC;
                if (sel_reg == SEL_C)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = ST_SRD;
                end
            end
            ST_OUT:
            begin
                if (!resp_valid_reg || resp_ready)
                begin
                    cmd.step   = STEP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // response valid flag
    always_comb
    begin
        resp_valid_next = resp_valid_reg;
        if (cmd.step == STEP_OUT)
        begin
            resp_valid_next = 1'b1;
        end
        else if (resp_ready)
        begin
            resp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            sel_reg        <= SEL_A;
            resp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            sel_reg        <= sel_next;
            resp_valid_reg <= resp_valid_next;
        end
    end

    assign resp_valid = resp_valid_reg;
endmodule
